>>> rtl/core/mra_pkg.sv
package mra_pkg;

	localparam int unsigned MOTION_BIT = 7;

	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_REPORT_INTERVAL = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_INVERT_Y        = 1'd1;

	localparam logic signed [15:0] S16_MIN   = 16'sh8000;
	localparam logic signed [15:0] S16_MAX   = 16'sh7FFF;
	localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;

	typedef struct packed {
		logic [7:0]  motion_status;
		logic [7:0]  delta_x_low;
		logic [7:0]  delta_x_high;
		logic [7:0]  delta_y_low;
		logic [7:0]  delta_y_high;
		logic [31:0] now_ms;
	} in_beat_t;

	typedef struct packed {
		logic signed [15:0] report_x;
		logic signed [15:0] report_y;
		logic [31:0]        report_time;
	} out_beat_t;

	// Decoded displacement of one sample.
	typedef struct packed {
		logic signed [15:0] dx;
		logic signed [15:0] dy;
	} delta_t;

	typedef struct packed {
		logic [15:0] report_interval_ms;
		logic        invert_y;
	} cfg_t;

endpackage

>>> rtl/core/mra_decode.sv
module mra_decode (
	input  mra_pkg::in_beat_t sample,
	input  logic              invert_y,
	output mra_pkg::delta_t   delta
);
	import mra_pkg::*;

	logic               motion;
	logic signed [15:0] raw_x;
	logic signed [15:0] raw_y;

	assign motion = sample.motion_status[MOTION_BIT];
	assign raw_x  = motion ? {sample.delta_x_high, sample.delta_x_low} : 16'sd0;
	assign raw_y  = motion ? {sample.delta_y_high, sample.delta_y_low} : 16'sd0;

	always_comb begin
		delta.dx = raw_x;
		if (invert_y) begin
			// Negating the most negative value saturates to the largest positive one.
			delta.dy = (raw_y == S16_MIN) ? S16_MAX : -raw_y;
		end else begin
			delta.dy = raw_y;
		end
	end

endmodule

>>> rtl/core/mra_accum.sv
module mra_accum (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [15:0]       report_interval_ms,
	input  logic [31:0]       now_ms,
	input  mra_pkg::delta_t   delta,
	output logic              emit,
	output mra_pkg::out_beat_t report
);
	import mra_pkg::*;

	logic signed [31:0] sum_x_q;
	logic signed [31:0] sum_y_q;
	logic [31:0]        last_sample_q;
	logic [31:0]        last_report_q;

	logic               timed;
	logic [31:0]        since_sample;
	logic [31:0]        since_report;
	logic               stale;
	logic signed [31:0] base_x;
	logic signed [31:0] base_y;
	logic signed [31:0] new_x;
	logic signed [31:0] new_y;

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
			input logic signed [15:0] b);
		logic signed [32:0] s;
		s = {a[31], a} + {{17{b[15]}}, b};
		if (s[32] != s[31]) begin
			sat_add = s[32] ? INT32_MIN : INT32_MAX;
		end else begin
			sat_add = s[31:0];
		end
	endfunction

	function automatic logic signed [15:0] clamp16(input logic signed [31:0] v);
		if (v > 32'(S16_MAX)) begin
			clamp16 = S16_MAX;
		end else if (v < 32'(S16_MIN)) begin
			clamp16 = S16_MIN;
		end else begin
			clamp16 = v[15:0];
		end
	endfunction

	assign timed        = report_interval_ms != 16'd0;
	assign since_sample = now_ms - last_sample_q;
	assign since_report = now_ms - last_report_q;
	assign stale        = timed && (since_sample >= {16'd0, report_interval_ms});
	assign base_x       = stale ? 32'sd0 : sum_x_q;
	assign base_y       = stale ? 32'sd0 : sum_y_q;
	assign new_x        = sat_add(base_x, delta.dx);
	assign new_y        = sat_add(base_y, delta.dy);
	assign emit         = !timed || (since_report >= {16'd0, report_interval_ms});

	assign report.report_x    = clamp16(new_x);
	assign report.report_y    = clamp16(new_y);
	assign report.report_time = now_ms;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q       <= '0;
			sum_y_q       <= '0;
			last_sample_q <= '0;
			last_report_q <= '0;
		end else if (advance) begin
			sum_x_q <= emit ? 32'sd0 : new_x;
			sum_y_q <= emit ? 32'sd0 : new_y;
			if (timed) begin
				last_sample_q <= now_ms;
				if (emit) begin
					last_report_q <= now_ms;
				end
			end
		end
	end

endmodule

>>> rtl/core/motion_report_accumulator_unit.sv
// Motion report accumulator. Each input beat carries one optical motion sample
// (status byte, X and Y displacement byte pairs, millisecond timestamp). The
// block accumulates the displacements into saturating 32-bit sums and emits a
// report beat with both sums clamped to 16 bits once report_interval_ms has
// passed since the previous report; with an interval of zero every sample
// reports. A sample that arrives after a gap of at least the interval first
// clears the sums. The block takes one sample per clock cycle while no reporting
// sample waits on a full output register. A sample is held in the input
// register, where the decode, the accumulate and the interval compares are
// evaluated against the state; its report then sits in the output register
// until taken, and is offered only from there. Samples that produce no report
// leave without using the output register, so a stalled output only blocks
// samples that would report.
module motion_report_accumulator_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  mra_pkg::in_beat_t                    in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output mra_pkg::out_beat_t                   out_data,
	input  logic                                 cfg_we,
	input  logic [mra_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [mra_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import mra_pkg::*;

	// Configuration registers, written only while the block is idle (user-enforced).
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REPORT_INTERVAL: cfg_q.report_interval_ms <= cfg_data;
				REG_INVERT_Y:        cfg_q.invert_y <= cfg_data[0];
				default:             cfg_q <= cfg_q;
			endcase
		end
	end

	// Input register: holds the sample being evaluated this cycle.
	logic     valid_s1;
	in_beat_t data_s1;
	logic     advance;
	logic     emit;
	out_beat_t report;
	delta_t   delta;

	// The sample in the input register moves on when it does not report, or
	// when the output register is empty or being emptied this cycle.
	assign advance  = valid_s1 && (!emit || !out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	mra_decode u_decode (
		.sample   (data_s1),
		.invert_y (cfg_q.invert_y),
		.delta    (delta)
	);

	// The accumulator state updates at the same edge the sample leaves, so the
	// next sample in the input register already sees the updated sums.
	mra_accum u_accum (
		.clk                (clk),
		.arst_n             (arst_n),
		.advance            (advance),
		.report_interval_ms (cfg_q.report_interval_ms),
		.now_ms             (data_s1.now_ms),
		.delta              (delta),
		.emit               (emit),
		.report             (report)
	);

	// Output register: a report waits here until the consumer takes it.
	logic      out_valid_q;
	out_beat_t out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_data_q <= report;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> bench/tb_motion_report_accumulator_unit.sv
`timescale 1ns / 100ps

// Testbench for the motion report accumulator. Samples go in as beats over a
// valid/ready channel and reports come back the same way. A predictor in this
// module tracks the accumulated displacement and the two interval timestamps.
// For every accepted sample that makes a report it queues the expected report.
// A checker process compares each report beat with the oldest queued one.
module tb_motion_report_accumulator_unit;

	import mra_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	in_beat_t               in_data = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	out_beat_t              out_data;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// Predictor copy of the block's state and configuration.
	int          acc_x = 0;
	int          acc_y = 0;
	logic [31:0] prev_sample_ms = '0;
	logic [31:0] prev_report_ms = '0;
	logic [15:0] interval_ms = '0;
	logic        flip_y = 1'b0;

	// Reports that the predictor has produced and the block has not yet sent.
	out_beat_t expected_reports[$];
	out_beat_t oldest_report;
	int        fault_count = 0;

	// Percent chance per cycle that the sample side idles or the report side
	// stalls. Each test sets these before it starts sending.
	int idle_pct = 0;
	int stall_pct = 0;

	motion_report_accumulator_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Saturating 32-bit add, done in 64 bits so the true sum is visible.
	function automatic int sat_add32(input int a, input int b);
		longint total;
		total = longint'(a) + longint'(b);
		if (total > longint'(INT32_MAX))
			return INT32_MAX;
		if (total < longint'(INT32_MIN))
			return INT32_MIN;
		return int'(total);
	endfunction

	// Clamp an accumulated sum to the signed 16-bit report range.
	function automatic logic signed [15:0] clamp16(input int v);
		if (v > int'(S16_MAX))
			return S16_MAX;
		if (v < int'(S16_MIN))
			return S16_MIN;
		return v[15:0];
	endfunction

	// Advance the predictor by one accepted sample. If the sample triggers a
	// report, the report is queued.
	task automatic predict_report(input in_beat_t beat);
		logic signed [15:0] raw_x;
		logic signed [15:0] raw_y;
		int                 dx;
		int                 dy;
		logic               timed;
		out_beat_t          rpt;
		dx = 0;
		dy = 0;
		timed = (interval_ms != 16'd0);
		if (beat.motion_status[MOTION_BIT]) begin
			raw_x = {beat.delta_x_high, beat.delta_x_low};
			raw_y = {beat.delta_y_high, beat.delta_y_low};
			dx = raw_x;
			dy = raw_y;
		end
		// Negating the most negative 16-bit value has no positive twin, so it
		// saturates to the largest positive one.
		if (flip_y)
			dy = (dy == int'(S16_MIN)) ? int'(S16_MAX) : -dy;

		// A long enough gap since the previous sample throws away whatever had
		// piled up. With a zero interval none of the timestamps are touched.
		if (timed) begin
			if (beat.now_ms - prev_sample_ms >= {16'd0, interval_ms}) begin
				acc_x = 0;
				acc_y = 0;
			end
			prev_sample_ms = beat.now_ms;
		end
		acc_x = sat_add32(acc_x, dx);
		acc_y = sat_add32(acc_y, dy);

		// The time differences wrap modulo 2^32, just as the timestamps do.
		if (!(timed && (beat.now_ms - prev_report_ms < {16'd0, interval_ms}))) begin
			rpt.report_x = clamp16(acc_x);
			rpt.report_y = clamp16(acc_y);
			rpt.report_time = beat.now_ms;
			expected_reports.push_back(rpt);
			acc_x = 0;
			acc_y = 0;
			if (timed)
				prev_report_ms = beat.now_ms;
		end
	endtask

	function automatic in_beat_t make_beat(input logic [7:0] status, input logic [15:0] dx,
			input logic [15:0] dy, input logic [31:0] now);
		in_beat_t beat;
		beat.motion_status = status;
		beat.delta_x_low = dx[7:0];
		beat.delta_x_high = dx[15:8];
		beat.delta_y_low = dy[7:0];
		beat.delta_y_high = dy[15:8];
		beat.now_ms = now;
		return beat;
	endfunction

	// Offer one sample. Random idle cycles come first. Valid is left high
	// after the handshake, so a sample that follows at once needs no second
	// assignment to valid in the same time step. Whoever stops sending lowers
	// valid.
	task automatic send_sample(input in_beat_t beat);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_report(beat);
	endtask

	// Stop sending and wait until every queued report has come back. Waiting
	// then goes on for samples that make no report but may still sit in the
	// input register.
	task automatic drain_reports();
		in_valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_REPORT_INTERVAL: interval_ms = val;
			REG_INVERT_Y: flip_y = val[0];
			default: ;
		endcase
	endtask

	// Reconfigure only once the block has gone idle. The upper bits of the
	// invert write are random because only bit 0 counts.
	task automatic set_config(input logic [15:0] interval, input logic invert);
		drain_reports();
		write_reg(REG_REPORT_INTERVAL, interval);
		write_reg(REG_INVERT_Y, {15'($urandom), invert});
	endtask

	// Half boundary values, a quarter small ones so that the sums stay inside
	// the report range, and the rest fully random.
	function automatic logic [15:0] pick_delta();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'hFFFF;
			3: return 16'h0001;
			4, 5: return 16'($urandom_range(0, 511) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	// Report checker and receiver stall generator. Both use the values from
	// just before the edge, so the order of processes inside a time step does
	// not matter.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_reports.size() == 0) begin
				$error("report beat with no sample behind it: x=%0d y=%0d time=%0d",
					out_data.report_x, out_data.report_y, out_data.report_time);
				fault_count++;
			end else begin
				oldest_report = expected_reports.pop_front();
				if (out_data.report_x !== oldest_report.report_x) begin
					$error("report_x: expected %0d, got %0d",
						oldest_report.report_x, out_data.report_x);
					fault_count++;
				end
				if (out_data.report_y !== oldest_report.report_y) begin
					$error("report_y: expected %0d, got %0d",
						oldest_report.report_y, out_data.report_y);
					fault_count++;
				end
				if (out_data.report_time !== oldest_report.report_time) begin
					$error("report_time: expected %0d, got %0d",
						oldest_report.report_time, out_data.report_time);
					fault_count++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// With a zero interval every sample reports on its own, so each report
	// shows how one sample was decoded: the motion bit, the sign extension
	// of both byte pairs, and the Y negation including its saturating corner.
	task automatic test_every_sample_reports();
		idle_pct = 0;
		stall_pct = 0;
		set_config(16'd0, 1'b0);
		send_sample(make_beat(8'h00, 16'h7FFF, 16'h8000, 32'd17));
		send_sample(make_beat(8'h7F, 16'h1234, 16'hFEDC, 32'd18));
		send_sample(make_beat(8'h80, 16'h7FFF, 16'h8000, 32'd19));
		send_sample(make_beat(8'hFF, 16'h8000, 16'h7FFF, 32'd0));
		send_sample(make_beat(8'h80, 16'hFFFF, 16'h0001, 32'hFFFF_FFFF));
		send_sample(make_beat(8'h80, 16'h0000, 16'h0000, 32'h8000_0000));
		set_config(16'd0, 1'b1);
		send_sample(make_beat(8'h80, 16'h0001, 16'h8000, 32'd20));
		send_sample(make_beat(8'hC3, 16'h8000, 16'h7FFF, 32'd21));
		send_sample(make_beat(8'h80, 16'h0000, 16'hFFFF, 32'd22));
		send_sample(make_beat(8'h00, 16'h7FFF, 16'h8000, 32'd23));
	endtask

	// A ten millisecond interval. Samples close together pile up without a
	// report, and a report arrives once the interval has passed since the
	// last one. A long gap clears the sums before the add. The timestamps
	// also wrap through zero. The two largest deltas early on drive the sums
	// past the 16-bit report range.
	task automatic test_interval_gating();
		logic [31:0] stamps[10];
		int          n;
		stamps = '{32'd1000, 32'd1005, 32'd1008, 32'd1010, 32'd1015, 32'd1030,
			32'hFFFF_FFF8, 32'hFFFF_FFFE, 32'd3, 32'd13};
		idle_pct = 0;
		stall_pct = 0;
		set_config(16'd10, 1'b0);
		for (n = 0; n < 10; n++) begin
			if (n == 1 || n == 2)
				send_sample(make_beat(8'h80, 16'h7FFF, 16'h8000, stamps[n]));
			else
				send_sample(make_beat(8'h80, 16'(n * 37), 16'(-n * 11), stamps[n]));
		end
	endtask

	// Pile many largest deltas into the sums. With the widest interval and a
	// frozen timestamp, no sample clears or reports, so the sums run far past
	// the 16-bit report range and the report must be clamped at both limits.
	task automatic test_sum_saturation();
		logic [31:0] start_ms;
		int          n;
		idle_pct = 0;
		stall_pct = 0;
		set_config(16'hFFFF, 1'b0);
		start_ms = 32'h4000_0000;
		// This sample lies far past the last report, so it reports and sets
		// the report time.
		send_sample(make_beat(8'h00, 16'h0000, 16'h0000, start_ms));
		for (n = 0; n < 60; n++)
			send_sample(make_beat(8'h80, 16'h7FFF, 16'h8000, start_ms));
		// Push the sums the other way. This must not pull them back into range.
		send_sample(make_beat(8'h80, 16'h8000, 16'h7FFF, start_ms + 32'd40000));
		send_sample(make_beat(8'h80, 16'h0000, 16'h0000, start_ms + 32'd65535));
		drain_reports();
	endtask

	// Random streams under four plans of idling and stalling, each with three
	// settings: report every sample, a short interval, and a long one, the widest
	// value in the two plans without sender idling. Timestamps mostly creep forward
	// by up to two intervals plus three, so samples land on both sides of the
	// clearing and reporting thresholds. Now and then the time stays frozen or jumps anywhere.
	task automatic test_random_streams();
		int          idle_plan[4];
		int          stall_plan[4];
		int          p;
		int          k;
		int          n;
		logic [15:0] interval;
		logic [7:0]  status;
		logic [31:0] stamp;
		idle_plan = '{0, 54, 0, 38};
		stall_plan = '{0, 0, 54, 38};
		stamp = $urandom;
		for (p = 0; p < 4; p++) begin
			for (k = 0; k < 3; k++) begin
				case (k)
					0: interval = 16'd0;
					1: interval = (p == 0) ? 16'd1 : 16'($urandom_range(2, 40));
					default: interval = (p % 2 == 0) ? 16'hFFFF : 16'($urandom_range(41, 65535));
				endcase
				set_config(interval, 1'((p + k) % 2));
				idle_pct = idle_plan[p];
				stall_pct = stall_plan[p];
				for (n = 0; n < 84; n++) begin
					// Once, pause the sender until every report has come back.
					if (p == 1 && k == 1 && n == 46)
						drain_reports();
					status = 8'($urandom);
					if ($urandom_range(0, 4) != 0)
						status[MOTION_BIT] = 1'b1;
					case ($urandom_range(0, 9))
						0: stamp = $urandom;
						1: ;
						default: stamp = stamp + $urandom_range(0, 2 * int'(interval) + 3);
					endcase
					send_sample(make_beat(status, pick_delta(), pick_delta(), stamp));
				end
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_every_sample_reports();
		test_interval_gating();
		test_sum_saturation();
		test_random_streams();
		drain_reports();
		if (fault_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog for a block that hangs. The slowest correct run takes only a
	// fraction of this.
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/mra_pkg.sv
rtl/core/mra_decode.sv
rtl/core/mra_accum.sv
rtl/core/motion_report_accumulator_unit.sv
bench/tb_motion_report_accumulator_unit.sv
